/* sv/bptc_pkg.sv */
// Shared types, constants and register codes of the pressure and temperature compensation block.
package bptc_pkg;

    localparam int DEF_SCALED_FRACTION_BITS = 24;
    localparam int RAW_W      = 24;
    localparam int OUT_W      = 32;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int PIPE_DEPTH = 9;

    // Integer headroom above the fraction bits of the scaled values and the sums.
    localparam int PS_HEAD = 7;
    localparam int P_HEAD  = 34;
    localparam int T_HEAD  = 18;

    localparam logic [63:0] SCALE_TAB [8] = '{
        64'd524288, 64'd1572864, 64'd3670016, 64'd7864320,
        64'd253952, 64'd516096,  64'd1040384, 64'd2088960
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERSAMPLING,
        CFG_TEMP_COEFFS,
        CFG_PRESS_OFFSET_LINEAR,
        CFG_TEMP_LINEAR,
        CFG_CROSS,
        CFG_SQUARE,
        CFG_CROSS_SQUARE,
        CFG_CUBE
    } t_cfg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] pressure;
        logic signed [OUT_W-1:0] temperature;
    } t_out;

    typedef struct packed {
        logic [2:0]          osr;
        logic signed [11:0]  c0;
        logic signed [11:0]  c1;
        logic signed [19:0]  c00;
        logic signed [19:0]  c10;
        logic signed [15:0]  c01;
        logic signed [15:0]  c11;
        logic signed [15:0]  c20;
        logic signed [15:0]  c21;
        logic signed [15:0]  c30;
    } t_coeffs;

endpackage

/* sv/bptc_cfg_regs.sv */
// Configuration register file holding the oversampling select and the calibration coefficients.
module bptc_cfg_regs
    import bptc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    output t_coeffs               o_coef
);

    t_coeffs r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OVERSAMPLING: begin
                    r_coef.osr <= i_cfg_wr_data[2:0];
                end
                CFG_TEMP_COEFFS: begin
                    r_coef.c0 <= i_cfg_wr_data[23:12];
                    r_coef.c1 <= i_cfg_wr_data[11:0];
                end
                CFG_PRESS_OFFSET_LINEAR: begin
                    r_coef.c00 <= i_cfg_wr_data[39:20];
                    r_coef.c10 <= i_cfg_wr_data[19:0];
                end
                CFG_TEMP_LINEAR: begin
                    r_coef.c01 <= i_cfg_wr_data[15:0];
                end
                CFG_CROSS: begin
                    r_coef.c11 <= i_cfg_wr_data[15:0];
                end
                CFG_SQUARE: begin
                    r_coef.c20 <= i_cfg_wr_data[15:0];
                end
                CFG_CROSS_SQUARE: begin
                    r_coef.c21 <= i_cfg_wr_data[15:0];
                end
                CFG_CUBE: begin
                    r_coef.c30 <= i_cfg_wr_data[15:0];
                end
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

/* sv/bptc_scale.sv */
// Two pipeline stages that scale the raw readings by the selected reciprocal.
module bptc_scale
    import bptc_pkg::*;
#(
    parameter int SCALED_FRACTION_BITS = DEF_SCALED_FRACTION_BITS
) (
    input  logic                                      i_clk,
    input  logic [1:0]                                i_en,
    input  t_in                                       i_data,
    input  logic [2:0]                                i_osr,
    output logic signed [SCALED_FRACTION_BITS+PS_HEAD-1:0] o_psc,
    output logic signed [SCALED_FRACTION_BITS+PS_HEAD-1:0] o_tsc
);

    localparam int F       = SCALED_FRACTION_BITS;
    localparam int RECIP_W = F + 15;
    localparam int PROD_W  = RAW_W + RECIP_W + 1;
    localparam int PS_W    = F + PS_HEAD;

    localparam logic [63:0] RECIP_TAB [8] = '{
        ((64'd1 << (F + 32)) + SCALE_TAB[0] / 2) / SCALE_TAB[0],
        ((64'd1 << (F + 32)) + SCALE_TAB[1] / 2) / SCALE_TAB[1],
        ((64'd1 << (F + 32)) + SCALE_TAB[2] / 2) / SCALE_TAB[2],
        ((64'd1 << (F + 32)) + SCALE_TAB[3] / 2) / SCALE_TAB[3],
        ((64'd1 << (F + 32)) + SCALE_TAB[4] / 2) / SCALE_TAB[4],
        ((64'd1 << (F + 32)) + SCALE_TAB[5] / 2) / SCALE_TAB[5],
        ((64'd1 << (F + 32)) + SCALE_TAB[6] / 2) / SCALE_TAB[6],
        ((64'd1 << (F + 32)) + SCALE_TAB[7] / 2) / SCALE_TAB[7]
    };

    localparam logic signed [PROD_W-1:0] HALF_32 = PROD_W'(64'h8000_0000);

    logic signed [RECIP_W:0]   recip;
    logic signed [PROD_W-1:0]  n_pr;
    logic signed [PROD_W-1:0]  n_tr;
    logic signed [PROD_W-1:0]  r_pr;
    logic signed [PROD_W-1:0]  r_tr;
    logic signed [PROD_W-1:0]  sum_p;
    logic signed [PROD_W-1:0]  sum_t;
    logic signed [PS_W-1:0]    r_psc;
    logic signed [PS_W-1:0]    r_tsc;

    assign recip = $signed({1'b0, RECIP_TAB[i_osr][RECIP_W-1:0]});
    assign n_pr  = $signed(i_data.raw_pressure) * recip;
    assign n_tr  = $signed(i_data.raw_temperature) * recip;
    assign sum_p = r_pr + HALF_32;
    assign sum_t = r_tr + HALF_32;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pr <= n_pr;
            r_tr <= n_tr;
        end
        if (i_en[1]) begin
            r_psc <= $signed(sum_p[32 +: PS_W]);
            r_tsc <= $signed(sum_t[32 +: PS_W]);
        end
    end

    assign o_psc = r_psc;
    assign o_tsc = r_tsc;

endmodule

/* sv/bptc_poly.sv */
// Six pipeline stages that evaluate the temperature and pressure polynomials.
module bptc_poly
    import bptc_pkg::*;
#(
    parameter int SCALED_FRACTION_BITS = DEF_SCALED_FRACTION_BITS
) (
    input  logic                                          i_clk,
    input  logic [5:0]                                    i_en,
    input  t_coeffs                                       i_coef,
    input  logic signed [SCALED_FRACTION_BITS+PS_HEAD-1:0] i_psc,
    input  logic signed [SCALED_FRACTION_BITS+PS_HEAD-1:0] i_tsc,
    output logic signed [SCALED_FRACTION_BITS+P_HEAD-1:0]  o_p,
    output logic signed [SCALED_FRACTION_BITS+T_HEAD-1:0]  o_t
);

    localparam int F     = SCALED_FRACTION_BITS;
    localparam int PS_W  = F + PS_HEAD;
    localparam int A_W   = F + 22;
    localparam int A_LO  = A_W / 2;
    localparam int AL_W  = PS_W + A_LO + 1;
    localparam int AH_W  = PS_W + A_W - A_LO;
    localparam int FA_W  = PS_W + A_W;
    localparam int B_W   = F + 28;
    localparam int B_LO  = B_W / 2;
    localparam int BL_W  = PS_W + B_LO + 1;
    localparam int BH_W  = PS_W + B_W - B_LO;
    localparam int FB_W  = PS_W + B_W;
    localparam int Q_W   = F + 33;
    localparam int C01_W = PS_W + 16;
    localparam int P_W   = F + P_HEAD;
    localparam int T_W   = F + T_HEAD;

    localparam logic signed [FA_W-1:0] HALF_A = FA_W'(64'd1 << (F - 1));
    localparam logic signed [FB_W-1:0] HALF_B = FB_W'(64'd1 << (F - 1));

    logic signed [PS_W+15:0] c30p;
    logic signed [PS_W+15:0] c21p;
    logic signed [PS_W+11:0] c1t;
    logic signed [FA_W-1:0]  sum_a;
    logic signed [FA_W-1:0]  sum_u;
    logic signed [FB_W-1:0]  sum_b;
    logic signed [FB_W-1:0]  sum_v;

    logic signed [A_W-1:0]   r_a2, r_u2;
    logic signed [PS_W-1:0]  r_psc2, r_tsc2, r_psc3, r_tsc3, r_psc4, r_tsc4;
    logic signed [C01_W-1:0] r_c01t2, r_c01t3, r_c01t4, r_c01t5, r_c01t6;
    logic signed [T_W-1:0]   r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    logic signed [AL_W-1:0]  r_al3, r_ul3;
    logic signed [AH_W-1:0]  r_ah3, r_uh3;
    logic signed [B_W-1:0]   r_b4, r_v4;
    logic signed [BL_W-1:0]  r_bl5, r_vl5;
    logic signed [BH_W-1:0]  r_bh5, r_vh5;
    logic signed [Q_W-1:0]   r_q2, r_q3;
    logic signed [P_W-1:0]   r_p7;

    assign c30p = i_coef.c30 * i_psc;
    assign c21p = i_coef.c21 * i_psc;
    assign c1t  = i_coef.c1 * i_tsc;

    assign sum_a = (FA_W'(r_ah3) <<< A_LO) + FA_W'(r_al3) + HALF_A;
    assign sum_u = (FA_W'(r_uh3) <<< A_LO) + FA_W'(r_ul3) + HALF_A;
    assign sum_b = (FB_W'(r_bh5) <<< B_LO) + FB_W'(r_bl5) + HALF_B;
    assign sum_v = (FB_W'(r_vh5) <<< B_LO) + FB_W'(r_vl5) + HALF_B;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a2    <= (A_W'(i_coef.c20) <<< F) + A_W'(c30p);
            r_u2    <= (A_W'(i_coef.c11) <<< F) + A_W'(c21p);
            r_c01t2 <= i_coef.c01 * i_tsc;
            r_t2    <= (T_W'(i_coef.c0) <<< (F - 1)) + T_W'(c1t);
            r_psc2  <= i_psc;
            r_tsc2  <= i_tsc;
        end
        if (i_en[1]) begin
            r_al3   <= r_psc2 * $signed({1'b0, r_a2[A_LO-1:0]});
            r_ah3   <= r_psc2 * $signed(r_a2[A_W-1:A_LO]);
            r_ul3   <= r_psc2 * $signed({1'b0, r_u2[A_LO-1:0]});
            r_uh3   <= r_psc2 * $signed(r_u2[A_W-1:A_LO]);
            r_psc3  <= r_psc2;
            r_tsc3  <= r_tsc2;
            r_c01t3 <= r_c01t2;
            r_t3    <= r_t2;
        end
        if (i_en[2]) begin
            r_b4    <= (B_W'(i_coef.c10) <<< F) + $signed(sum_a[F +: B_W]);
            r_v4    <= $signed(sum_u[F +: B_W]);
            r_psc4  <= r_psc3;
            r_tsc4  <= r_tsc3;
            r_c01t4 <= r_c01t3;
            r_t4    <= r_t3;
        end
        if (i_en[3]) begin
            r_bl5   <= r_psc4 * $signed({1'b0, r_b4[B_LO-1:0]});
            r_bh5   <= r_psc4 * $signed(r_b4[B_W-1:B_LO]);
            r_vl5   <= r_tsc4 * $signed({1'b0, r_v4[B_LO-1:0]});
            r_vh5   <= r_tsc4 * $signed(r_v4[B_W-1:B_LO]);
            r_c01t5 <= r_c01t4;
            r_t5    <= r_t4;
        end
        if (i_en[4]) begin
            r_q2    <= $signed(sum_b[F +: Q_W]);
            r_q3    <= $signed(sum_v[F +: Q_W]);
            r_c01t6 <= r_c01t5;
            r_t6    <= r_t5;
        end
        if (i_en[5]) begin
            r_p7 <= (P_W'(i_coef.c00) <<< F) + P_W'(r_q2) + P_W'(r_q3) + P_W'(r_c01t6);
            r_t7 <= r_t6;
        end
    end

    assign o_p = r_p7;
    assign o_t = r_t7;

endmodule

/* sv/bptc_round.sv */
// Output stage that rounds both sums to their output units and saturates the pressure.
module bptc_round
    import bptc_pkg::*;
#(
    parameter int SCALED_FRACTION_BITS = DEF_SCALED_FRACTION_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic signed [SCALED_FRACTION_BITS+P_HEAD-1:0] i_p,
    input  logic signed [SCALED_FRACTION_BITS+T_HEAD-1:0] i_t,
    output t_out                                         o_data
);

    localparam int F    = SCALED_FRACTION_BITS;
    localparam int P_W  = F + P_HEAD;
    localparam int T_W  = F + T_HEAD;
    localparam int P_SH = F - 6;
    localparam int T_SH = F - 8;
    localparam int RP_W = P_W - P_SH;
    localparam int RT_W = T_W - T_SH;

    localparam logic signed [P_W-1:0]  HALF_P = P_W'(64'd1 << (P_SH - 1));
    localparam logic signed [T_W-1:0]  HALF_T = T_W'(64'd1 << (T_SH - 1));
    localparam logic signed [RP_W-1:0] MAX_P  = RP_W'(64'sh7fff_ffff);
    localparam logic signed [RP_W-1:0] MIN_P  = RP_W'(-64'sh8000_0000);

    logic signed [P_W-1:0]   sum_p;
    logic signed [T_W-1:0]   sum_t;
    logic signed [RP_W-1:0]  rp;
    logic signed [RT_W-1:0]  rt;
    logic signed [OUT_W-1:0] n_pressure;
    t_out                    r_data;

    assign sum_p = i_p + HALF_P;
    assign sum_t = i_t + HALF_T;
    assign rp    = $signed(sum_p[P_SH +: RP_W]);
    assign rt    = $signed(sum_t[T_SH +: RT_W]);

    always_comb begin
        priority if (rp > MAX_P) begin
            n_pressure = OUT_W'(MAX_P);
        end else if (rp < MIN_P) begin
            n_pressure = OUT_W'(MIN_P);
        end else begin
            n_pressure = OUT_W'(rp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data.pressure    <= n_pressure;
            r_data.temperature <= OUT_W'(rt);
        end
    end

    assign o_data = r_data;

endmodule

/* sv/barometer_pressure_temp_compensation.sv */
// Top level of the pressure and temperature compensation pipeline.
// An accepted request passes the scale, polynomial and rounding stages into the output register.
// Throughput: one request per cycle unless stalled; a stage moves when empty or the next moves.
// A stalled output holds only the stages behind it that are full, so bubbles are filled.
// Reset clears the stage valid bits and all configuration registers to zero.
module barometer_pressure_temp_compensation
    import bptc_pkg::*;
#(
    parameter int SCALED_FRACTION_BITS = DEF_SCALED_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data
);

    localparam int F = SCALED_FRACTION_BITS;

    t_coeffs                       coef;
    logic [PIPE_DEPTH-1:0]         r_vld;
    logic [PIPE_DEPTH-1:0]         n_vld;
    logic [PIPE_DEPTH-1:0]         stage_ready;
    logic signed [F+PS_HEAD-1:0]   psc;
    logic signed [F+PS_HEAD-1:0]   tsc;
    logic signed [F+P_HEAD-1:0]    p_sum;
    logic signed [F+T_HEAD-1:0]    t_sum;

    always_comb begin
        stage_ready[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            stage_ready[k] = !r_vld[k] || stage_ready[k+1];
        end
    end

    always_comb begin
        n_vld[0] = stage_ready[0] ? i_valid : r_vld[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_vld[k] = stage_ready[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !stage_ready[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    bptc_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_coef        (coef)
    );

    bptc_scale #(
        .SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
    ) u_scale (
        .i_clk  (i_clk),
        .i_en   (stage_ready[1:0]),
        .i_data (i_data),
        .i_osr  (coef.osr),
        .o_psc  (psc),
        .o_tsc  (tsc)
    );

    bptc_poly #(
        .SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
    ) u_poly (
        .i_clk  (i_clk),
        .i_en   (stage_ready[7:2]),
        .i_coef (coef),
        .i_psc  (psc),
        .i_tsc  (tsc),
        .o_p    (p_sum),
        .o_t    (t_sum)
    );

    bptc_round #(
        .SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
    ) u_round (
        .i_clk  (i_clk),
        .i_en   (stage_ready[8]),
        .i_p    (p_sum),
        .i_t    (t_sum),
        .o_data (o_data)
    );

endmodule

/* sv/bptc_checker.sv */
// Port-level assertions for the compensation pipeline and their binding to the top level.
module bptc_checker
    import bptc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled result request changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result request shown right after reset.");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0 && r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("Result request without a matching input request.");

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("Input stalled while the output side is free.");

endmodule

bind barometer_pressure_temp_compensation bptc_checker u_bptc_checker (.*);
